### design/fem_element_matrix_1d_defines.svh
// Assertion macros shared by the checker of the element matrix block.
// No dependencies; included by the checker file only.
`ifndef FEM_ELEMENT_MATRIX_1D_DEFINES_SVH
`define FEM_ELEMENT_MATRIX_1D_DEFINES_SVH
// Implication checked at every clock edge outside reset.
`define FEM_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define FEM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`endif

### design/fem_pkg.sv
// Shared types and constants of the 1D element matrix block.
// No dependencies.
package fem_pkg;
	localparam logic [2:0] OP_SHAPE = 3'd0;
	localparam logic [2:0] OP_DERIV = 3'd1;
	localparam logic [2:0] OP_WEIGHT = 3'd2;
	localparam logic [2:0] OP_COEFF = 3'd3;
	localparam logic [2:0] OP_COMPUTE = 3'd4;
	localparam int NCOEF = 6;
	localparam logic [1:0] REG_NUM_SHAPES = 2'd0;
	localparam logic [1:0] REG_NUM_QUAD = 2'd1;
	localparam logic [1:0] REG_PRESENT = 2'd2;
	localparam logic [1:0] REG_EXPANDED = 2'd3;
	localparam logic signed [47:0] ACC_MAX = 48'sh7FFF_FFFF_FFFF;
	localparam logic signed [47:0] ACC_MIN = 48'sh8000_0000_0000;

	// Compute job handed from the front part to the back part.
	typedef struct packed {
		logic [1:0] ns;
		logic [3:0] nq;
		logic [5:0] present;
		logic [5:0] expanded;
	} job_t;

	// Round a Q16.48 product to Q16.24, ties upwards.
	function automatic logic signed [39:0] qround(input logic signed [63:0] p);
		logic signed [63:0] t;
		begin
			t = p + 64'sd8388608;
			qround = t[63:24];
		end
	endfunction

	// Clamp to the signed 32-bit range.
	function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
		begin
			if (v > 40'sd2147483647)
				sat32 = 32'sh7FFF_FFFF;
			else if (v < -40'sd2147483648)
				sat32 = 32'sh8000_0000;
			else
				sat32 = v[31:0];
		end
	endfunction
endpackage

### design/fem_front.sv
// Front part: accepts items, writes loads to the tables, queues compute jobs.
// Depends on fem_pkg.
module fem_front #(
	parameter int MAX_SHAPES = 3,
	parameter int MAX_QUAD = 4
) (
	input logic clk,
	input logic arst_n,
	input logic s_axis_tvalid,
	output logic s_axis_tready,
	input logic [41:0] s_axis_tdata,
	input logic [1:0] num_shapes,
	input logic [2:0] num_quad,
	input logic [5:0] present_mask,
	input logic [5:0] expanded_mask,
	input logic back_busy,
	output logic job_valid,
	input logic job_take,
	output fem_pkg::job_t job,
	output logic tbl_we,
	output logic [2:0] tbl_kind,
	output logic [1:0] tbl_shape,
	output logic [2:0] tbl_quad,
	output logic [2:0] tbl_coeff,
	output logic [31:0] tbl_data
);
	import fem_pkg::*;

	logic [2:0] opcode;
	logic [1:0] si;
	logic [1:0] qi;
	logic [2:0] ci;
	logic acc;
	logic addr_ok;
	logic job_valid_q;
	job_t job_q;
	job_t job_d;

	assign opcode = s_axis_tdata[2:0];
	assign si = s_axis_tdata[4:3];
	assign qi = s_axis_tdata[6:5];
	assign ci = s_axis_tdata[9:7];
	assign tbl_data = s_axis_tdata[41:10];

	// Loads wait while a job is queued or running so tables stay stable.
	assign s_axis_tready = !job_valid_q && !back_busy;
	assign acc = s_axis_tvalid && s_axis_tready;

	always_comb begin
		addr_ok = 32'(qi) < MAX_QUAD;
		case (opcode)
			OP_SHAPE, OP_DERIV: addr_ok = addr_ok && (32'(si) < 32'(MAX_SHAPES));
			OP_WEIGHT: addr_ok = addr_ok;
			OP_COEFF: addr_ok = addr_ok && (ci < 3'(NCOEF));
			default: addr_ok = 1'b0;
		endcase
	end

	assign tbl_we = acc && addr_ok;
	assign tbl_kind = opcode;
	assign tbl_shape = si;
	assign tbl_quad = {1'b0, qi};
	assign tbl_coeff = ci;

	// Clamp counts once when the job is queued.
	always_comb begin
		job_d.ns = (num_shapes == 2'd0) ? 2'd1 :
			((32'(num_shapes) > MAX_SHAPES) ? 2'(MAX_SHAPES) : num_shapes);
		job_d.nq = (32'(num_quad) > MAX_QUAD) ? 4'(MAX_QUAD) : {1'b0, num_quad};
		job_d.present = present_mask;
		job_d.expanded = expanded_mask;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			job_valid_q <= 1'b0;
		end else if (acc && opcode == OP_COMPUTE) begin
			job_valid_q <= 1'b1;
		end else if (job_take) begin
			job_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc && opcode == OP_COMPUTE) begin
			job_q <= job_d;
		end
	end

	assign job_valid = job_valid_q;
	assign job = job_q;
endmodule

### design/fem_back.sv
// Back part: walks entries, coefficients and points with one shared multiplier.
// Depends on fem_pkg.
module fem_back #(
	parameter int MAX_SHAPES = 3,
	parameter int MAX_QUAD = 4
) (
	input logic clk,
	input logic arst_n,
	input logic job_valid,
	output logic job_take,
	input fem_pkg::job_t job,
	output logic busy,
	input logic tbl_we,
	input logic [2:0] tbl_kind,
	input logic [1:0] tbl_shape,
	input logic [2:0] tbl_quad,
	input logic [2:0] tbl_coeff,
	input logic [31:0] tbl_data,
	output logic m_valid,
	input logic m_ready,
	output logic [52:0] m_data,
	output logic m_last
);
	import fem_pkg::*;

	localparam int QW = (MAX_QUAD > 1) ? $clog2(MAX_QUAD) : 1;
	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_M1 = 3'd1;
	localparam logic [2:0] ST_M2 = 3'd2;
	localparam logic [2:0] ST_M3 = 3'd3;
	localparam logic [2:0] ST_OUT = 3'd4;

	logic signed [31:0] shape_q [MAX_SHAPES][MAX_QUAD];
	logic signed [31:0] deriv_q [MAX_SHAPES][MAX_QUAD];
	logic signed [31:0] weight_q [MAX_QUAD];
	logic signed [31:0] coeff_q [NCOEF][MAX_QUAD];

	logic [2:0] state_q;
	job_t job_q;
	logic [1:0] s_q, r_q;
	logic vec_q;
	logic [2:0] k_q;
	logic [3:0] q_q;
	logic signed [47:0] acc_q;
	logic signed [31:0] p_q;
	logic out_valid_q;
	logic [52:0] out_data_q;
	logic out_last_q;

	logic [QW-1:0] qx, qc;
	logic signed [31:0] fs, fr, cf, ma, mb;
	logic signed [63:0] prod;
	logic signed [39:0] rnd;
	logic signed [48:0] sum;
	logic signed [47:0] sum_sat;
	logic k_on, term_end, k_end, last_entry;
	logic [2:0] k_next;

	// Table writes from the front part.
	always_ff @(posedge clk) begin
		if (tbl_we) begin
			case (tbl_kind)
				OP_SHAPE: shape_q[tbl_shape][tbl_quad[QW-1:0]] <= tbl_data;
				OP_DERIV: deriv_q[tbl_shape][tbl_quad[QW-1:0]] <= tbl_data;
				OP_WEIGHT: weight_q[tbl_quad[QW-1:0]] <= tbl_data;
				OP_COEFF: coeff_q[tbl_coeff][tbl_quad[QW-1:0]] <= tbl_data;
				default: ;
			endcase
		end
	end

	// Operand selection for the present term.
	always_comb begin
		qx = q_q[QW-1:0];
		qc = job_q.expanded[k_q] ? qx : '0;
		fs = (k_q == 3'd0 || k_q == 3'd1 || k_q == 3'd4) ? deriv_q[s_q][qx] : shape_q[s_q][qx];
		fr = (k_q == 3'd0 || k_q == 3'd2) ? deriv_q[r_q][qx] : shape_q[r_q][qx];
		cf = coeff_q[k_q][qc];
		case (state_q)
			ST_M1: begin ma = weight_q[qx]; mb = fs; end
			ST_M2: begin ma = p_q; mb = cf; end
			default: begin ma = p_q; mb = fr; end
		endcase
		prod = ma * mb;
		rnd = qround(prod);
		sum = 49'(acc_q) + 49'(rnd);
		if (sum > 49'(ACC_MAX)) sum_sat = ACC_MAX;
		else if (sum < 49'(ACC_MIN)) sum_sat = ACC_MIN;
		else sum_sat = sum[47:0];
		k_on = job_q.present[k_q] && (job_q.nq != 4'd0);
		term_end = (q_q + 4'd1 >= job_q.nq);
		k_end = vec_q ? (k_q == 3'd5) : (k_q == 3'd3);
		k_next = k_q + 3'd1;
		last_entry = vec_q && (s_q + 2'd1 == job_q.ns);
	end

	assign busy = (state_q != ST_IDLE) || out_valid_q;
	assign job_take = job_valid && (state_q == ST_IDLE) && !out_valid_q;

	// Sequencer over entry, coefficient and quadrature point.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: if (job_take) begin
					state_q <= ST_M1;
				end
				ST_M1: if (!k_on) begin
					if (k_end) state_q <= ST_OUT;
				end else begin
					state_q <= ST_M2;
				end
				ST_M2: if (vec_q) begin
					state_q <= (term_end && k_end) ? ST_OUT : ST_M1;
				end else begin
					state_q <= ST_M3;
				end
				ST_M3: state_q <= (term_end && k_end) ? ST_OUT : ST_M1;
				ST_OUT: if (!out_valid_q || m_ready) begin
					state_q <= last_entry ? ST_IDLE : ST_M1;
				end
				default: state_q <= ST_IDLE;
			endcase
			// The output register is refilled from ST_OUT once it is empty or its transfer completes.
			if (state_q == ST_OUT && (!out_valid_q || m_ready)) out_valid_q <= 1'b1;
			else if (m_ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				job_q <= job;
				s_q <= 2'd0; r_q <= 2'd0; vec_q <= 1'b0;
				k_q <= 3'd0; q_q <= 4'd0; acc_q <= '0;
			end
			ST_M1: begin
				if (!k_on) begin
					if (!k_end) k_q <= k_next;
				end else begin
					p_q <= sat32(rnd);
				end
			end
			ST_M2: begin
				if (vec_q) begin
					acc_q <= sum_sat;
					if (term_end) begin
						q_q <= 4'd0;
						if (!k_end) k_q <= k_next;
					end else begin
						q_q <= q_q + 4'd1;
					end
				end else begin
					p_q <= sat32(rnd);
				end
			end
			ST_M3: begin
				acc_q <= sum_sat;
				if (term_end) begin
					q_q <= 4'd0;
					if (!k_end) k_q <= k_next;
				end else begin
					q_q <= q_q + 4'd1;
				end
			end
			ST_OUT: if (!out_valid_q || m_ready) begin
				out_data_q <= {acc_q, 1'b1 & vec_q, vec_q ? 2'd0 : r_q, s_q};
				out_last_q <= last_entry;
				acc_q <= '0;
				q_q <= 4'd0;
				if (!vec_q && r_q + 2'd1 == job_q.ns) begin
					r_q <= 2'd0;
					if (s_q + 2'd1 == job_q.ns) begin
						s_q <= 2'd0; vec_q <= 1'b1; k_q <= 3'd4;
					end else begin
						s_q <= s_q + 2'd1; k_q <= 3'd0;
					end
				end else if (!vec_q) begin
					r_q <= r_q + 2'd1; k_q <= 3'd0;
				end else begin
					s_q <= s_q + 2'd1; k_q <= 3'd4;
				end
			end
			default: ;
		endcase
	end

	assign m_valid = out_valid_q;
	assign m_data = out_data_q;
	assign m_last = out_last_q;
endmodule

### design/fem_element_matrix_1d.sv
// Sequence: a compute job is queued in the front part and taken once the back part is idle.
// Per point of a present coefficient a matrix entry passes ST_M1, ST_M2 and ST_M3, a vector
// entry ST_M1, ST_M2; an absent coefficient (all if nq is zero) ST_M1; each entry ST_OUT.
// Input: no item is accepted while a job is queued or running or an entry waits.
// Reset: arst_n clears control and sets num_shapes 2, num_quad 2, masks 0.
// Tables are undefined until written.
module fem_element_matrix_1d #(
	parameter int MAX_SHAPES = 3,
	parameter int MAX_QUAD = 4
) (
	input logic clk,
	input logic arst_n,
	input logic s_axis_tvalid,
	output logic s_axis_tready,
	// opcode, shape_index, quad_index, coeff_select, load_value, zero fill
	input logic [47:0] s_axis_tdata,
	output logic m_axis_tvalid,
	input logic m_axis_tready,
	// row, col, is_vector, entry_value, zero fill
	output logic [55:0] m_axis_tdata,
	output logic m_axis_tlast,
	input logic cfg_we,
	input logic [1:0] cfg_index,
	input logic [5:0] cfg_data
);
	import fem_pkg::*;

	logic [1:0] num_shapes_q;
	logic [2:0] num_quad_q;
	logic [5:0] present_q, expanded_q;
	logic job_valid, job_take, busy, tbl_we;
	job_t job;
	logic [2:0] tbl_kind, tbl_quad, tbl_coeff;
	logic [1:0] tbl_shape;
	logic [31:0] tbl_data;
	logic [52:0] m_data;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_shapes_q <= 2'd2; num_quad_q <= 3'd2;
			present_q <= '0; expanded_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_NUM_SHAPES: num_shapes_q <= cfg_data[1:0];
				REG_NUM_QUAD: num_quad_q <= cfg_data[2:0];
				REG_PRESENT: present_q <= cfg_data;
				REG_EXPANDED: expanded_q <= cfg_data;
				default: ;
			endcase
		end
	end

	fem_front #(.MAX_SHAPES(MAX_SHAPES), .MAX_QUAD(MAX_QUAD)) u_front (
		.clk, .arst_n, .s_axis_tvalid, .s_axis_tready,
		.s_axis_tdata(s_axis_tdata[41:0]),
		.num_shapes(num_shapes_q), .num_quad(num_quad_q),
		.present_mask(present_q), .expanded_mask(expanded_q),
		.back_busy(busy), .job_valid, .job_take, .job,
		.tbl_we, .tbl_kind, .tbl_shape, .tbl_quad, .tbl_coeff, .tbl_data
	);

	fem_back #(.MAX_SHAPES(MAX_SHAPES), .MAX_QUAD(MAX_QUAD)) u_back (
		.clk, .arst_n, .job_valid, .job_take, .job, .busy,
		.tbl_we, .tbl_kind, .tbl_shape, .tbl_quad, .tbl_coeff, .tbl_data,
		.m_valid(m_axis_tvalid), .m_ready(m_axis_tready), .m_data,
		.m_last(m_axis_tlast)
	);

	assign m_axis_tdata = {3'd0, m_data};
endmodule

### design/fem_element_matrix_1d_checker.sv
// Port-level checker for the element matrix block, bound to the top level.
// Depends on fem_element_matrix_1d_defines.svh.
`include "fem_element_matrix_1d_defines.svh"
module fem_element_matrix_1d_checker (
	input logic clk,
	input logic arst_n,
	input logic s_axis_tvalid,
	input logic s_axis_tready,
	input logic m_axis_tvalid,
	input logic m_axis_tready,
	input logic [55:0] m_axis_tdata,
	input logic m_axis_tlast
);
	`FEM_ASSERT_NEXT(a_out_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))
	`FEM_ASSERT_IMP(a_last_vec, clk, arst_n, m_axis_tvalid && m_axis_tlast, m_axis_tdata[4])
	`FEM_ASSERT_IMP(a_vec_col, clk, arst_n, m_axis_tvalid && m_axis_tdata[4], m_axis_tdata[3:2] == 2'd0)
	`FEM_ASSERT_IMP(a_no_in_out, clk, arst_n, m_axis_tvalid, !s_axis_tready)
endmodule

bind fem_element_matrix_1d fem_element_matrix_1d_checker u_checker (
	.clk, .arst_n, .s_axis_tvalid, .s_axis_tready, .m_axis_tvalid,
	.m_axis_tready, .m_axis_tdata, .m_axis_tlast
);

### verif/fem_element_matrix_1d_test.sv
// Self-checking testbench for the 1D finite element local matrix block.
// Depends directly on fem_pkg and fem_element_matrix_1d, which needs fem_front and fem_back.
module fem_element_matrix_1d_test;
	timeunit 1ns;
	timeprecision 1ps;
	import fem_pkg::*;

	localparam int NSH = 3;
	localparam int NQ = 4;
	localparam int WATCH_LIMIT = 3000;
	localparam int ITEM_TARGET = 420;

	// One output entry of the element: matrix entry or right-hand side entry.
	typedef struct packed {
		logic [1:0] row;
		logic [1:0] col;
		logic is_vec;
		logic signed [47:0] value;
		logic last;
	} entry_t;

	// A row of the directed table: a register setting or an input item.
	typedef struct {
		bit is_cfg;
		logic [2:0] op;
		logic [1:0] si;
		logic [1:0] qi;
		logic [2:0] ci;
		logic [31:0] val;
		bit zero_out;
		logic [1:0] c_ns;
		logic [2:0] c_nq;
		logic [5:0] c_pm;
		logic [5:0] c_em;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [47:0] s_axis_tdata = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b1;
	logic [55:0] m_axis_tdata;
	logic m_axis_tlast;
	logic cfg_we = 1'b0;
	logic [1:0] cfg_index = '0;
	logic [5:0] cfg_data = '0;

	// Own copy of the tables and registers.
	logic signed [31:0] shape_tab [NSH*NQ];
	logic signed [31:0] deriv_tab [NSH*NQ];
	logic signed [31:0] weight_tab [NQ];
	logic signed [31:0] coeff_tab [NCOEF*NQ];
	logic [1:0] reg_ns = 2'd2;
	logic [2:0] reg_nq = 3'd2;
	logic [5:0] reg_pm = '0;
	logic [5:0] reg_em = '0;

	entry_t pending_entries [$];
	int errors = 0;
	int items_sent = 0;
	int entries_seen = 0;
	int computes_sent = 0;
	int idle_cycles = 0;
	bit tx_steady = 1'b0;
	bit rx_steady = 1'b0;
	int rx_wait = 0;

	fem_element_matrix_1d dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tlast(m_axis_tlast),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	// Q8.24 multiply, rounded to nearest with ties upwards.
	function automatic longint qmul(input longint a, input longint b);
		longint p;
		p = a * b + 64'sd8388608;
		return p >>> 24;
	endfunction

	function automatic longint clamp32(input longint v);
		if (v > 64'sd2147483647)
			return 64'sd2147483647;
		if (v < -64'sd2147483648)
			return -64'sd2147483648;
		return v;
	endfunction

	function automatic longint acc_sum(input longint acc, input longint t);
		longint s;
		s = acc + t;
		if (s > 64'sd140737488355327)
			return 64'sd140737488355327;
		if (s < -64'sd140737488355328)
			return -64'sd140737488355328;
		return s;
	endfunction

	function automatic longint coeff_at(input int k, input int q);
		return coeff_tab[k*NQ + (reg_em[k] ? q : 0)];
	endfunction

	// Matrix entry (s,r) from coefficients A to D.
	function automatic longint stiffness_entry(input int s, input int r, input int nq);
		longint acc, fs, fr, p1, p2;
		acc = 0;
		for (int k = 0; k < 4; k++) begin
			if (reg_pm[k]) begin
				for (int q = 0; q < nq; q++) begin
					fs = (k < 2) ? deriv_tab[s*NQ+q] : shape_tab[s*NQ+q];
					fr = (k == 0 || k == 2) ? deriv_tab[r*NQ+q] : shape_tab[r*NQ+q];
					p1 = clamp32(qmul(weight_tab[q], fs));
					p2 = clamp32(qmul(p1, coeff_at(k, q)));
					acc = acc_sum(acc, qmul(p2, fr));
				end
			end
		end
		return acc;
	endfunction

	// Right-hand side entry s from coefficients X and Y.
	function automatic longint load_entry(input int s, input int nq);
		longint acc, fs, p1;
		acc = 0;
		for (int k = 4; k < NCOEF; k++) begin
			if (reg_pm[k]) begin
				for (int q = 0; q < nq; q++) begin
					fs = (k == 4) ? deriv_tab[s*NQ+q] : shape_tab[s*NQ+q];
					p1 = clamp32(qmul(weight_tab[q], fs));
					acc = acc_sum(acc, qmul(p1, coeff_at(k, q)));
				end
			end
		end
		return acc;
	endfunction

	// Apply one accepted item to the tables, or queue the element's entries.
	function automatic void assemble_item(input logic [2:0] op, input logic [1:0] si,
		input logic [1:0] qi, input logic [2:0] ci, input logic [31:0] val,
		input bit zero_out);
		int ns, nq;
		entry_t e;
		case (op)
			OP_SHAPE: if (si < NSH) shape_tab[si*NQ+qi] = val;
			OP_DERIV: if (si < NSH) deriv_tab[si*NQ+qi] = val;
			OP_WEIGHT: weight_tab[qi] = val;
			OP_COEFF: if (ci < NCOEF) coeff_tab[ci*NQ+qi] = val;
			OP_COMPUTE: begin
				ns = (reg_ns == 0) ? 1 : ((reg_ns > NSH) ? NSH : reg_ns);
				nq = (reg_nq > NQ) ? NQ : reg_nq;
				for (int s = 0; s < ns; s++) begin
					for (int r = 0; r < ns; r++) begin
						e.row = 2'(s);
						e.col = 2'(r);
						e.is_vec = 1'b0;
						e.value = zero_out ? 48'sd0 : 48'(stiffness_entry(s, r, nq));
						e.last = 1'b0;
						pending_entries.push_back(e);
					end
				end
				for (int s = 0; s < ns; s++) begin
					e.row = 2'(s);
					e.col = 2'd0;
					e.is_vec = 1'b1;
					e.value = zero_out ? 48'sd0 : 48'(load_entry(s, nq));
					e.last = (s == ns - 1);
					pending_entries.push_back(e);
				end
			end
			default: ;
		endcase
	endfunction

	// Send one item, predict it on acceptance, then idle for a drawn gap.
	task automatic send_item(input logic [2:0] op, input logic [1:0] si, input logic [1:0] qi,
		input logic [2:0] ci, input logic [31:0] val, input bit zero_out);
		int gap;
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {6'd0, val, ci, qi, si, op};
		do
			@(posedge clk);
		while (!s_axis_tready);
		assemble_item(op, si, qi, ci, val, zero_out);
		items_sent++;
		if (op == OP_COMPUTE)
			computes_sent++;
		gap = tx_steady ? 0 : $urandom_range(0, 18);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Wait until every queued entry has arrived and the block has settled.
	task automatic drain;
		s_axis_tvalid <= 1'b0;
		while (pending_entries.size() != 0)
			@(posedge clk);
		repeat (30) @(posedge clk);
	endtask

	// Write all four registers on consecutive edges.
	task automatic set_regs(input logic [1:0] ns, input logic [2:0] nq, input logic [5:0] pm,
		input logic [5:0] em);
		logic [5:0] vals [4];
		logic [1:0] idx [4];
		vals = '{6'(ns), 6'(nq), pm, em};
		idx = '{REG_NUM_SHAPES, REG_NUM_QUAD, REG_PRESENT, REG_EXPANDED};
		for (int i = 0; i < 4; i++) begin
			cfg_we <= 1'b1;
			cfg_index <= idx[i];
			cfg_data <= vals[i];
			@(posedge clk);
		end
		cfg_we <= 1'b0;
		reg_ns = ns;
		reg_nq = nq;
		reg_pm = pm;
		reg_em = em;
	endtask

	function automatic logic [31:0] draw_value;
		if ($urandom_range(0, 1))
			return $urandom;
		return 32'($urandom_range(0, 32'h0400_0000)) - 32'h0200_0000;
	endfunction

	// Output side: stall for a drawn number of cycles after each transfer.
	always @(posedge clk) begin
		if (m_axis_tvalid && m_axis_tready) begin
			rx_wait = rx_steady ? 0 : $urandom_range(0, 18);
			if (rx_wait > 0)
				m_axis_tready <= 1'b0;
		end else if (!m_axis_tready) begin
			if (rx_wait <= 1)
				m_axis_tready <= 1'b1;
			else
				rx_wait = rx_wait - 1;
		end
	end

	// Compare each output transfer with the oldest expected entry.
	always @(posedge clk) begin
		entry_t got, want;
		if (m_axis_tvalid && m_axis_tready) begin
			got.row = m_axis_tdata[1:0];
			got.col = m_axis_tdata[3:2];
			got.is_vec = m_axis_tdata[4];
			got.value = m_axis_tdata[52:5];
			got.last = m_axis_tlast;
			entries_seen++;
			if (pending_entries.size() == 0) begin
				errors++;
				$display("%0t: unexpected entry row %0d col %0d vec %0d value %0d", $time,
					got.row, got.col, got.is_vec, got.value);
			end else begin
				want = pending_entries.pop_front();
				if (got != want) begin
					errors++;
					$display("%0t: entry mismatch expected r%0d c%0d v%0d %0d last %0d,",
						$time, want.row, want.col, want.is_vec, want.value, want.last);
					$display("    actual r%0d c%0d v%0d %0d last %0d", got.row, got.col,
						got.is_vec, got.value, got.last);
				end
			end
		end
	end

	// Watchdog on cycles without any transfer.
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCH_LIMIT) begin
			$display("%0t: watchdog expired with %0d entries pending", $time,
				pending_entries.size());
			$display("DONE: errors detected");
			$finish;
		end
	end

	initial begin
		dir_row_t plan [$];
		dir_row_t d;
		int r;
		logic [2:0] op;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Fill every table entry so that no compute reads an unwritten one.
		tx_steady = 1'b1;
		for (int s = 0; s < NSH; s++)
			for (int q = 0; q < NQ; q++) begin
				send_item(OP_SHAPE, 2'(s), 2'(q), 3'd0, draw_value(), 1'b0);
				send_item(OP_DERIV, 2'(s), 2'(q), 3'd0, draw_value(), 1'b0);
			end
		for (int q = 0; q < NQ; q++)
			send_item(OP_WEIGHT, 2'd0, 2'(q), 3'd0, draw_value(), 1'b0);
		for (int k = 0; k < NCOEF; k++)
			for (int q = 0; q < NQ; q++)
				send_item(OP_COEFF, 2'd0, 2'(q), 3'(k), draw_value(), 1'b0);
		tx_steady = 1'b0;

		// Directed table. Reset masks are clear, so the first computes give zeros.
		d = '{default: '0};
		d.op = OP_COMPUTE; d.zero_out = 1; plan.push_back(d);
		d = '{default: '0}; d.op = 3'd5; d.val = 32'hFFFF_FFFF; d.si = 3; d.qi = 3; d.ci = 7;
		plan.push_back(d);
		d.op = 3'd6; plan.push_back(d);
		d.op = 3'd7; plan.push_back(d);
		// Out-of-range load addresses are ignored.
		d = '{default: '0}; d.op = OP_SHAPE; d.si = 3; d.val = 32'h7FFF_FFFF; plan.push_back(d);
		d.op = OP_DERIV; plan.push_back(d);
		d = '{default: '0}; d.op = OP_COEFF; d.ci = 6; d.val = 32'h8000_0000; plan.push_back(d);
		d.ci = 7; d.qi = 3; plan.push_back(d);
		// Extreme values that drive the 32-bit clamps.
		d = '{default: '0}; d.op = OP_WEIGHT; d.val = 32'h7FFF_FFFF; plan.push_back(d);
		d = '{default: '0}; d.op = OP_DERIV; d.val = 32'h8000_0000; plan.push_back(d);
		d = '{default: '0}; d.op = OP_SHAPE; d.si = 1; d.qi = 1; d.val = 32'h8000_0000;
		plan.push_back(d);
		d = '{default: '0}; d.op = OP_COEFF; d.val = 32'h7FFF_FFFF; plan.push_back(d);
		d = '{default: '0}; d.op = OP_COEFF; d.ci = 5; d.qi = 3; d.val = 32'h8000_0000;
		plan.push_back(d);
		d = '{default: '0}; d.op = OP_COMPUTE; d.zero_out = 1; plan.push_back(d);
		d = '{default: '0}; d.is_cfg = 1; d.c_ns = 2; d.c_nq = 2; d.c_pm = 63; d.c_em = 63;
		plan.push_back(d);
		d = '{default: '0}; d.op = OP_COMPUTE; plan.push_back(d);
		d = '{default: '0}; d.is_cfg = 1; d.c_ns = 3; d.c_nq = 4; d.c_pm = 63; d.c_em = 0;
		plan.push_back(d);
		d = '{default: '0}; d.op = OP_COMPUTE; plan.push_back(d);
		// No quadrature points: every sum is zero; zero shapes count as one.
		d = '{default: '0}; d.is_cfg = 1; d.c_ns = 0; d.c_nq = 0; d.c_pm = 63; d.c_em = 63;
		plan.push_back(d);
		d = '{default: '0}; d.op = OP_COMPUTE; d.zero_out = 1; plan.push_back(d);
		// Counts above the maxima are clamped.
		d = '{default: '0}; d.is_cfg = 1; d.c_ns = 3; d.c_nq = 7; d.c_pm = 6'h2A;
		d.c_em = 6'h15; plan.push_back(d);
		d = '{default: '0}; d.op = OP_COMPUTE; plan.push_back(d);

		foreach (plan[i]) begin
			if (plan[i].is_cfg) begin
				drain();
				set_regs(plan[i].c_ns, plan[i].c_nq, plan[i].c_pm, plan[i].c_em);
			end else begin
				send_item(plan[i].op, plan[i].si, plan[i].qi, plan[i].ci, plan[i].val,
					plan[i].zero_out);
			end
		end

		// Random phases, each under its own register setting.
		for (int ph = 0; items_sent < ITEM_TARGET; ph++) begin
			drain();
			tx_steady = (ph % 3 == 2);
			rx_steady = (ph % 4 == 3);
			if (ph == 0)
				set_regs(2'd3, 3'd7, 6'd63, 6'd63);
			else if (ph == 1)
				set_regs(2'd0, 3'd1, 6'd0, 6'd0);
			else
				set_regs(2'($urandom_range(0, 3)), 3'($urandom_range(0, 7)),
					6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)));
			for (int n = 0; n < 40 && items_sent < ITEM_TARGET; n++) begin
				r = $urandom_range(0, 99);
				if (r < 15) begin
					send_item(OP_COMPUTE, 2'($urandom), 2'($urandom), 3'($urandom),
						$urandom, 1'b0);
				end else if (r < 25) begin
					// Unused opcodes and out-of-range addresses.
					case ($urandom_range(0, 2))
						0: send_item(3'($urandom_range(5, 7)), 2'($urandom), 2'($urandom),
							3'($urandom), $urandom, 1'b0);
						1: send_item(3'($urandom_range(0, 1)), 2'd3, 2'($urandom),
							3'($urandom), draw_value(), 1'b0);
						default: send_item(OP_COEFF, 2'($urandom), 2'($urandom),
							3'($urandom_range(6, 7)), draw_value(), 1'b0);
					endcase
				end else begin
					op = 3'($urandom_range(0, 3));
					send_item(op, 2'($urandom_range(0, 2)), 2'($urandom),
						3'($urandom_range(0, 5)), draw_value(), 1'b0);
				end
			end
		end

		drain();
		rx_steady = 1'b0;
		$display("Covered %0d items including %0d element computes, %0d entries checked.",
			items_sent, computes_sent, entries_seen);
		$display("Register settings ranged over zero and clamped counts and all mask values.");
		if (errors == 0 && pending_entries.size() == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end
endmodule

### sim.f
+incdir+design
design/fem_pkg.sv
design/fem_front.sv
design/fem_back.sv
design/fem_element_matrix_1d.sv
design/fem_element_matrix_1d_checker.sv
verif/fem_element_matrix_1d_test.sv
